[design/lerd_pkg.sv]
// ----------------------------------------------------------------------------
// lerd_pkg
// Shared types, constants and helpers of the level excursion run detector.
// ----------------------------------------------------------------------------
package lerd_pkg;

	localparam int COORD_W       = 32;
	localparam int SPEED_W       = 9;
	localparam int LEVEL_W       = 16;
	localparam int MAG_W         = LEVEL_W + 1;
	localparam int THR_W         = 11;
	localparam int MIN_LEN_W     = 20;
	localparam int SUM_W         = 32;
	localparam int CFG_DATA_W    = 32;
	localparam int CFG_ADDR_W    = 5;
	localparam int REG_IDX_W     = 3;

	localparam int DEF_COUNT_BITS      = 16;
	localparam int DEF_LEVEL_FRAC_BITS = 4;
	localparam int REC_QUEUE_DEPTH     = 2;

	localparam logic [THR_W-1:0]     RST_THR_FAST   = 11'd11;
	localparam logic [THR_W-1:0]     RST_THR_MEDIUM = 11'd11;
	localparam logic [THR_W-1:0]     RST_THR_SLOW   = 11'd15;
	localparam logic [SPEED_W-1:0]   RST_FAST_BREAK = 9'd120;
	localparam logic [SPEED_W-1:0]   RST_SLOW_BREAK = 9'd60;
	localparam logic [MIN_LEN_W-1:0] RST_MIN_LEN    = 20'd4000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THR_FAST    = 3'd0,
		REG_THR_MEDIUM  = 3'd1,
		REG_THR_SLOW    = 3'd2,
		REG_FAST_BREAK  = 3'd3,
		REG_SLOW_BREAK  = 3'd4,
		REG_MIN_RUN_LEN = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIVIDE,
		BK_HOLD
	} back_state_t;

	typedef struct packed {
		logic [COORD_W-1:0]        coord;
		logic [SPEED_W-1:0]        speed;
		logic signed [LEVEL_W-1:0] level;
		logic                      stretch_end;
	} sample_t;

	typedef struct packed {
		logic [COORD_W-1:0]        end_coord;
		logic [COORD_W-1:0]        run_length;
		logic signed [LEVEL_W-1:0] peak_level;
		logic signed [LEVEL_W-1:0] mean_level;
		logic [THR_W-1:0]          threshold_used;
		logic [SPEED_W-1:0]        min_speed;
		logic [SPEED_W-1:0]        max_speed;
	} result_t;

	typedef struct packed {
		logic [THR_W-1:0]     thr_fast;
		logic [THR_W-1:0]     thr_medium;
		logic [THR_W-1:0]     thr_slow;
		logic [SPEED_W-1:0]   speed_fast_break;
		logic [SPEED_W-1:0]   speed_slow_break;
		logic [MIN_LEN_W-1:0] min_run_length;
	} cfg_t;

	// closed run handed from front to back (sample count travels beside it)
	typedef struct packed {
		logic [COORD_W-1:0] end_coord;
		logic [COORD_W-1:0] run_length;
		logic [MAG_W-1:0]   peak_mag;
		logic [SUM_W-1:0]   mag_sum;
		logic               last_neg;
		logic [THR_W-1:0]   thr;
		logic [SPEED_W-1:0] speed_lo;
		logic [SPEED_W-1:0] speed_hi;
	} run_rec_t;

	// magnitude with sign applied, saturated to the 16-bit range
	function automatic logic [LEVEL_W-1:0] sign_level(input logic [SUM_W-1:0] mag,
		input logic neg);
		logic [MAG_W-1:0] m;
		m = (mag > 32'd32768) ? 17'd32768 : mag[MAG_W-1:0];
		if (neg) begin
			sign_level = LEVEL_W'(17'd0 - m);
		end else if (mag > 32'd32767) begin
			sign_level = 16'h7FFF;
		end else begin
			sign_level = mag[LEVEL_W-1:0];
		end
	endfunction

endpackage

[design/lerd_queue.sv]
// ----------------------------------------------------------------------------
// lerd_queue
// Small register queue between the run tracker and the reporting back end.
// ----------------------------------------------------------------------------
module lerd_queue import lerd_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = REC_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/lerd_front.sv]
// ----------------------------------------------------------------------------
// lerd_front
// Threshold selection, excursion classification and run tracking.
// ----------------------------------------------------------------------------
module lerd_front import lerd_pkg::*; #(
	parameter int COUNT_BITS      = DEF_COUNT_BITS,
	parameter int LEVEL_FRAC_BITS = DEF_LEVEL_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  accept,
	input  sample_t               sample,
	output logic                  rec_valid,
	output run_rec_t              rec,
	output logic [COUNT_BITS-1:0] rec_count
);

	localparam int THR_SH_W = THR_W + LEVEL_FRAC_BITS;
	localparam int CMP_W    = (THR_SH_W > MAG_W) ? THR_SH_W : MAG_W;

	logic                  active_q;
	logic [COORD_W-1:0]    start_q, prev_q;
	logic [MAG_W-1:0]      peak_q;
	logic [SUM_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  neg_q;
	logic [SPEED_W-1:0]    spd_lo_q, spd_hi_q;

	logic               neg;
	logic [MAG_W-1:0]   mag;
	logic [THR_W-1:0]   thr;
	logic               in_run;
	logic [COORD_W-1:0] span;
	logic               report;
	logic [SUM_W:0]     sum_ext;
	logic [SUM_W-1:0]   sum_next;

	assign neg = sample.level[LEVEL_W-1];
	assign mag = neg ? (MAG_W'(0) - {sample.level[LEVEL_W-1], sample.level})
	                 : {1'b0, sample.level};

	always_comb begin
		if (sample.speed > cfg.speed_fast_break) begin
			thr = cfg.thr_fast;
		end else if (sample.speed > cfg.speed_slow_break) begin
			thr = cfg.thr_medium;
		end else begin
			thr = cfg.thr_slow;
		end
	end

	// stretch end always closes the run
	assign in_run = (CMP_W'(mag) > (CMP_W'(thr) << LEVEL_FRAC_BITS)) && !sample.stretch_end;

	assign span   = prev_q - start_q;
	assign report = active_q && (prev_q >= start_q) && (span >= COORD_W'(cfg.min_run_length));

	assign sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(mag);
	assign sum_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

	assign rec_valid      = accept && !in_run && report;
	assign rec.end_coord  = sample.coord;
	assign rec.run_length = span;
	assign rec.peak_mag   = peak_q;
	assign rec.mag_sum    = sum_q;
	assign rec.last_neg   = neg_q;
	assign rec.thr        = thr;
	assign rec.speed_lo   = spd_lo_q;
	assign rec.speed_hi   = spd_hi_q;
	assign rec_count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			start_q  <= '0;
			prev_q   <= '0;
			peak_q   <= '0;
			sum_q    <= '0;
			count_q  <= '0;
			neg_q    <= 1'b0;
			spd_lo_q <= '1;
			spd_hi_q <= '0;
		end else if (accept) begin
			prev_q <= sample.coord;
			if (in_run) begin
				neg_q <= neg;
				if (!active_q) begin
					active_q <= 1'b1;
					start_q  <= sample.coord;
					peak_q   <= mag;
					sum_q    <= SUM_W'(mag);
					count_q  <= COUNT_BITS'(1);
					spd_lo_q <= sample.speed;
					spd_hi_q <= sample.speed;
				end else begin
					if (mag > peak_q) begin
						peak_q <= mag;
					end
					// count stops at its top value, and the sum with it
					if (!(&count_q)) begin
						sum_q   <= sum_next;
						count_q <= count_q + 1'b1;
					end
					if (sample.speed > spd_hi_q) begin
						spd_hi_q <= sample.speed;
					end
					if (sample.speed < spd_lo_q) begin
						spd_lo_q <= sample.speed;
					end
				end
			end else begin
				active_q <= 1'b0;
				start_q  <= '0;
				peak_q   <= '0;
				sum_q    <= '0;
				count_q  <= '0;
				neg_q    <= 1'b0;
				spd_lo_q <= '1;
				spd_hi_q <= '0;
			end
		end
	end

endmodule

[design/lerd_back.sv]
// ----------------------------------------------------------------------------
// lerd_back
// Mean division, sign and saturation, and the result register.
// ----------------------------------------------------------------------------
module lerd_back import lerd_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  run_rec_t              q_rec,
	input  logic [COUNT_BITS-1:0] q_count,
	output logic                  q_pop,
	output result_t               result,
	output logic                  empty,
	input  logic                  pop
);

	localparam int STEP_W = $clog2(SUM_W);

	back_state_t           state_q, state_next;
	run_rec_t              rec_q;
	logic [COUNT_BITS-1:0] div_q, rem_q;
	logic [SUM_W-1:0]      quo_q;
	logic [STEP_W-1:0]     step_q;
	logic                  out_valid_q;
	result_t               result_q;

	logic                  load_out;
	logic                  div_step;
	logic                  last_step;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS+1:0] diff;
	logic                  ge;

	assign last_step = (step_q == STEP_W'(SUM_W - 1));

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_next = BK_DIVIDE;
				end
			end
			BK_DIVIDE: begin
				if (last_step) begin
					state_next = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (!out_valid_q || pop) begin
					state_next = BK_IDLE;
				end
			end
			default: state_next = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		div_step = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE:   q_pop    = !q_empty;
			BK_DIVIDE: div_step = 1'b1;
			BK_HOLD:   load_out = !out_valid_q || pop;
			default: ;
		endcase
	end

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign ge    = !diff[COUNT_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q  <= q_rec;
			div_q  <= q_count;
			rem_q  <= '0;
			quo_q  <= q_rec.mag_sum;
			step_q <= '0;
		end else if (div_step) begin
			rem_q  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], ge};
			step_q <= step_q + 1'b1;
		end
		if (load_out) begin
			result_q.end_coord      <= rec_q.end_coord;
			result_q.run_length     <= rec_q.run_length;
			result_q.peak_level     <= sign_level(SUM_W'(rec_q.peak_mag), rec_q.last_neg);
			result_q.mean_level     <= sign_level(quo_q, rec_q.last_neg);
			result_q.threshold_used <= rec_q.thr;
			result_q.min_speed      <= rec_q.speed_lo;
			result_q.max_speed      <= rec_q.speed_hi;
		end
	end

	assign result = result_q;
	assign empty  = !out_valid_q;

endmodule

[design/level_excursion_run_detector_unit.sv]
// ----------------------------------------------------------------------------
// level_excursion_run_detector_unit
// Finds runs of track samples whose level exceeds a speed-banded threshold
// and reports peak, mean, length and speed range of each long enough run.
// ----------------------------------------------------------------------------
// The front end takes one sample per clock while full is low and keeps the
// running statistics of the current run; a sample that closes a reportable
// run drops a record into a two-entry queue. The back end divides the run's
// magnitude sum by its sample count with a one-bit-per-cycle restoring
// divider; each reported run passes through a load, 32 quotient steps and a
// hand-off into the result register, plus waiting for pop. The full flag
// rises only when both queue entries hold runs not yet taken by the divider.
// Configuration registers sit at byte addresses 0x00..0x14 (thr_fast,
// thr_medium, thr_slow, speed_fast_break, speed_slow_break, min_run_length)
// and may be written only while the block is idle.
module level_excursion_run_detector_unit import lerd_pkg::*; #(
	parameter int COUNT_BITS      = DEF_COUNT_BITS,
	parameter int LEVEL_FRAC_BITS = DEF_LEVEL_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample side
	input  logic                  push,
	output logic                  full,
	input  sample_t               sample,
	// result side
	input  logic                  pop,
	output logic                  empty,
	output result_t               result,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int REC_W = $bits(run_rec_t) + COUNT_BITS;

	cfg_t                  cfg_q;
	reg_idx_t              reg_idx;
	logic                  cfg_wr;

	logic                  accept;
	logic                  rec_valid;
	run_rec_t              rec;
	logic [COUNT_BITS-1:0] rec_count;
	logic                  q_full, q_empty, q_pop;
	logic [REC_W-1:0]      q_rdata;
	run_rec_t              q_rec;
	logic [COUNT_BITS-1:0] q_count;

	// configuration registers, written on the access phase of a transaction
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_fast         <= RST_THR_FAST;
			cfg_q.thr_medium       <= RST_THR_MEDIUM;
			cfg_q.thr_slow         <= RST_THR_SLOW;
			cfg_q.speed_fast_break <= RST_FAST_BREAK;
			cfg_q.speed_slow_break <= RST_SLOW_BREAK;
			cfg_q.min_run_length   <= RST_MIN_LEN;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_THR_FAST:    cfg_q.thr_fast         <= pwdata[THR_W-1:0];
				REG_THR_MEDIUM:  cfg_q.thr_medium       <= pwdata[THR_W-1:0];
				REG_THR_SLOW:    cfg_q.thr_slow         <= pwdata[THR_W-1:0];
				REG_FAST_BREAK:  cfg_q.speed_fast_break <= pwdata[SPEED_W-1:0];
				REG_SLOW_BREAK:  cfg_q.speed_slow_break <= pwdata[SPEED_W-1:0];
				REG_MIN_RUN_LEN: cfg_q.min_run_length   <= pwdata[MIN_LEN_W-1:0];
				default: ; // addresses past the register list are ignored
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			REG_THR_FAST:    prdata = CFG_DATA_W'(cfg_q.thr_fast);
			REG_THR_MEDIUM:  prdata = CFG_DATA_W'(cfg_q.thr_medium);
			REG_THR_SLOW:    prdata = CFG_DATA_W'(cfg_q.thr_slow);
			REG_FAST_BREAK:  prdata = CFG_DATA_W'(cfg_q.speed_fast_break);
			REG_SLOW_BREAK:  prdata = CFG_DATA_W'(cfg_q.speed_slow_break);
			REG_MIN_RUN_LEN: prdata = CFG_DATA_W'(cfg_q.min_run_length);
			default:         prdata = '0;
		endcase
	end

	// any sample may close a run, so hold off while the queue has no room
	assign full   = q_full;
	assign accept = push && !q_full;

	lerd_front #(
		.COUNT_BITS      (COUNT_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.sample    (sample),
		.rec_valid (rec_valid),
		.rec       (rec),
		.rec_count (rec_count)
	);

	// closed-run records waiting for the divider
	lerd_queue #(
		.WIDTH (REC_W),
		.DEPTH (REC_QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_valid),
		.wdata  ({rec_count, rec}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign q_rec   = q_rdata[$bits(run_rec_t)-1:0];
	assign q_count = q_rdata[REC_W-1:$bits(run_rec_t)];

	lerd_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rec   (q_rec),
		.q_count (q_count),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
